@@ src/bottom_up_merge_sorter_defines.svh @@
// ----------------------------------------------------------------------------
// bottom_up_merge_sorter_defines
// assertion macros used by the sorter's top level
// ----------------------------------------------------------------------------
`ifndef BOTTOM_UP_MERGE_SORTER_DEFINES_SVH
`define BOTTOM_UP_MERGE_SORTER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define BUMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define BUMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bums_pkg.sv @@
// ----------------------------------------------------------------------------
// bums_pkg
// shared types and constants of the bottom-up merge sorter
// ----------------------------------------------------------------------------
`default_nettype none

package bums_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int DATA_W        = 32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_RUN,
    ST_MRD,
    ST_MWR,
    ST_ERD,
    ST_ELD
  } state_t;

  typedef struct packed {
    logic wr_load;
    logic wr_merge;
    logic take_left;
    logic src_b;
    logic rd_en;
    logic out_load;
    logic out_final;
    logic out_dropped;
  } cmd_t;

  typedef struct packed {
    logic le;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ src/bums_datapath.sv @@
// ----------------------------------------------------------------------------
// bums_datapath
// two memory banks, merge compare and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module bums_datapath #(
  parameter int DEPTH = bums_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire bums_pkg::cmd_t                   cmd,
  output bums_pkg::stat_t                       stat,
  input  wire logic [AW-1:0]                    waddr,
  input  wire logic [AW-1:0]                    raddr0,
  input  wire logic [AW-1:0]                    raddr1,
  input  wire logic signed [bums_pkg::DATA_W-1:0] in_value,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [bums_pkg::DATA_W-1:0]           m_tdata,
  output logic                                  m_tlast,
  output logic                                  m_tuser
);

  logic [bums_pkg::DATA_W-1:0] bank_a [DEPTH];
  logic [bums_pkg::DATA_W-1:0] bank_b [DEPTH];
  logic [bums_pkg::DATA_W-1:0] rda0, rda1, rdb0, rdb1;
  logic [bums_pkg::DATA_W-1:0] rd0, rd1, wdata;
  logic                        we_a, we_b;

  assign rd0   = cmd.src_b ? rdb0 : rda0;
  assign rd1   = cmd.src_b ? rdb1 : rda1;
  assign wdata = cmd.wr_load ? in_value : (cmd.take_left ? rd0 : rd1);
  assign we_a  = cmd.wr_load || (cmd.wr_merge && cmd.src_b);
  assign we_b  = cmd.wr_merge && !cmd.src_b;

  assign stat.le       = $signed(rd0) <= $signed(rd1);
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (we_a) begin
      bank_a[waddr] <= wdata;
    end
    if (we_b) begin
      bank_b[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rda0 <= bank_a[raddr0];
      rda1 <= bank_a[raddr1];
      rdb0 <= bank_b[raddr0];
      rdb1 <= bank_b[raddr1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.out_load) begin
      m_tdata <= rd0;
      m_tlast <= cmd.out_final;
      m_tuser <= cmd.out_dropped;
    end
  end

endmodule

`default_nettype wire

@@ src/bums_ctrl.sv @@
// ----------------------------------------------------------------------------
// bums_ctrl
// sequencer for loading, merge passes and emission, with index counters
// ----------------------------------------------------------------------------
`default_nettype none

module bums_ctrl #(
  parameter int DEPTH = bums_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic            s_tlast,
  output bums_pkg::cmd_t       cmd,
  input  wire bums_pkg::stat_t stat,
  output logic [AW-1:0]        waddr,
  output logic [AW-1:0]        raddr0,
  output logic [AW-1:0]        raddr1
);

  bums_pkg::state_t st, st_next;

  logic [CW-1:0] cnt;
  logic          ovf;
  logic [CW:0]   w;
  logic [CW-1:0] base, mid, run_end, l, r, o;
  logic          src_b;

  logic          full, accept, take_left, run_done, set_done, last_out;
  logic [CW:0]   mid_sum, end_sum;
  logic [CW-1:0] mid_c, end_c;

  assign full      = cnt == CW'(DEPTH);
  assign accept    = (st == bums_pkg::ST_LOAD) && s_tvalid;
  assign take_left = (l < mid) && ((r >= run_end) || stat.le);
  assign run_done  = (o + 1'b1) == run_end;
  assign set_done  = run_end == cnt;
  assign last_out  = (o + 1'b1) == cnt;

  // run bounds, clipped at the set size
  assign mid_sum = {1'b0, base} + w;
  assign mid_c   = (mid_sum < {1'b0, cnt}) ? mid_sum[CW-1:0] : cnt;
  assign end_sum = {1'b0, mid_c} + w;
  assign end_c   = (end_sum < {1'b0, cnt}) ? end_sum[CW-1:0] : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= bums_pkg::ST_LOAD;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next         = st;
    s_tready        = 1'b0;
    cmd             = '0;
    cmd.src_b       = src_b;
    cmd.take_left   = take_left;
    cmd.out_final   = last_out;
    cmd.out_dropped = ovf;
    waddr           = o[AW-1:0];
    raddr0          = l[AW-1:0];
    raddr1          = r[AW-1:0];
    unique case (st)
      bums_pkg::ST_LOAD: begin
        s_tready    = 1'b1;
        waddr       = cnt[AW-1:0];
        cmd.wr_load = accept && !full;
        if (accept && s_tlast) begin
          st_next = bums_pkg::ST_PASS;
        end
      end
      bums_pkg::ST_PASS: begin
        st_next = (w < {1'b0, cnt}) ? bums_pkg::ST_RUN : bums_pkg::ST_ERD;
      end
      bums_pkg::ST_RUN: begin
        st_next = bums_pkg::ST_MRD;
      end
      bums_pkg::ST_MRD: begin
        cmd.rd_en = 1'b1;
        st_next   = bums_pkg::ST_MWR;
      end
      bums_pkg::ST_MWR: begin
        cmd.wr_merge = 1'b1;
        if (!run_done) begin
          st_next = bums_pkg::ST_MRD;
        end else if (set_done) begin
          st_next = bums_pkg::ST_PASS;
        end else begin
          st_next = bums_pkg::ST_RUN;
        end
      end
      bums_pkg::ST_ERD: begin
        cmd.rd_en = 1'b1;
        raddr0    = o[AW-1:0];
        st_next   = bums_pkg::ST_ELD;
      end
      bums_pkg::ST_ELD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          st_next      = last_out ? bums_pkg::ST_LOAD : bums_pkg::ST_ERD;
        end
      end
      default: begin
        st_next = bums_pkg::ST_LOAD;
      end
    endcase
  end

  // set size and overflow mark
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      if (!full) begin
        cnt <= cnt + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end else if (cmd.out_load && last_out) begin
      cnt <= '0;
      ovf <= 1'b0;
    end
  end

  // merge and emission indices
  always_ff @(posedge clk) begin
    unique case (st)
      bums_pkg::ST_LOAD: begin
        w     <= (CW+1)'(1);
        src_b <= 1'b0;
      end
      bums_pkg::ST_PASS: begin
        base <= '0;
        o    <= '0;
      end
      bums_pkg::ST_RUN: begin
        mid     <= mid_c;
        run_end <= end_c;
        l       <= base;
        r       <= mid_c;
        o       <= base;
      end
      bums_pkg::ST_MRD: begin
      end
      bums_pkg::ST_MWR: begin
        if (take_left) begin
          l <= l + 1'b1;
        end else begin
          r <= r + 1'b1;
        end
        o <= o + 1'b1;
        if (run_done) begin
          base <= run_end;
          if (set_done) begin
            src_b <= !src_b;
            w     <= {w[CW-1:0], 1'b0};
          end
        end
      end
      bums_pkg::ST_ERD: begin
      end
      bums_pkg::ST_ELD: begin
        if (stat.out_free) begin
          o <= o + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/bottom_up_merge_sorter.sv @@
// ----------------------------------------------------------------------------
// bottom_up_merge_sorter
// collects a set of signed values, sorts it by bottom-up merge passes
// between two banks and streams it out in ascending order
// ----------------------------------------------------------------------------
// channel  dir  tdata                 tlast      tuser
// s_*      in   [31:0] value          last       -
// m_*      out  [31:0] sorted_value   final_res  dropped
//
// loading takes one beat per cycle into bank a, up to DEPTH values
// sorting runs ceil(log2 n) passes; per element, a registered bank read
// (ST_MRD), then compare and write (ST_MWR), plus ST_RUN/ST_PASS setup
// emission reads a beat (ST_ERD), then loads it once the output is free
// no input is taken from the end of a set until its final beat is loaded
// rst is synchronous and returns the block to loading an empty set
// ----------------------------------------------------------------------------
`default_nettype none

`include "bottom_up_merge_sorter_defines.svh"

module bottom_up_merge_sorter #(
  parameter int DEPTH = bums_pkg::DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] sorted_value
  output logic             m_tlast,
  output logic             m_tuser    // [0] dropped
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bums_pkg::cmd_t  cmd;
  bums_pkg::stat_t stat;
  logic [AW-1:0]   waddr, raddr0, raddr1;

  bums_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .stat     (stat),
    .waddr    (waddr),
    .raddr0   (raddr0),
    .raddr1   (raddr1)
  );

  bums_datapath #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .waddr    (waddr),
    .raddr0   (raddr0),
    .raddr1   (raddr1),
    .in_value (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  `BUMS_ASSERT_NOW(a_wr_excl, cmd.wr_load, !cmd.wr_merge, "load and merge write together")
  `BUMS_ASSERT_NOW(a_no_overrun, cmd.out_load, stat.out_free, "output beat overwritten")
  `BUMS_ASSERT_NOW(a_no_input_sort, cmd.wr_merge || cmd.rd_en, !s_tready, "input open while sorting")
  `BUMS_ASSERT_NEXT(a_out_valid, cmd.out_load, m_tvalid, "loaded beat not presented")

endmodule

`default_nettype wire
